>>> rtl/circle_pair_collision_time_macros.svh
// ----------------------------------------------------------------------------
// circle_pair_collision_time assertion macros
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_COLLISION_TIME_MACROS_SVH
`define CIRCLE_PAIR_COLLISION_TIME_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define CPCT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cpct assertion failed");

// overlapping implication
`define CPCT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cpct implication failed");

// next-cycle implication
`define CPCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cpct next-cycle implication failed");

`endif

>>> rtl/cpct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpct_pkg
// Shared widths and the payload carried along the square-root cell chain.
// ----------------------------------------------------------------------------
package cpct_pkg;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned DIF_W  = 17;
  localparam int unsigned PRD_W  = 34;
  localparam int unsigned A_W    = 34;            // |v|^2
  localparam int unsigned H_W    = 35;            // p.v, signed
  localparam int unsigned C_W    = 35;            // |p|^2 - dist^2, signed
  localparam int unsigned M_W    = 34;            // magnitudes of h and c
  localparam int unsigned D_W    = 68;            // discriminant / 4
  localparam int unsigned R_W    = D_W / 2;       // root width
  localparam int unsigned REM_W  = R_W + 2;
  localparam int unsigned SQ_N   = D_W / 2;       // one cell per root bit
  localparam int unsigned NUM_W  = 36;            // -h - s, signed
  localparam int unsigned MAG_W  = NUM_W - 1;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned TIME_W = 32;
  localparam logic [CFG_W-1:0] CDS_RESET = 32'd671089;

  typedef struct packed {
    logic                    hit;
    logic signed [H_W-1:0]   h;
    logic [A_W-1:0]          a;
    logic [D_W-1:0]          d;
    logic [R_W-1:0]          root;
    logic [REM_W-1:0]        rem;
  } sq_t;

endpackage

>>> rtl/cpct_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpct_in_if
// Input channel: one circle pair per item.
// ----------------------------------------------------------------------------
interface cpct_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [cpct_pkg::IN_W-1:0] pos_a_x;
  logic signed [cpct_pkg::IN_W-1:0] pos_a_y;
  logic signed [cpct_pkg::IN_W-1:0] pos_b_x;
  logic signed [cpct_pkg::IN_W-1:0] pos_b_y;
  logic signed [cpct_pkg::IN_W-1:0] vel_a_x;
  logic signed [cpct_pkg::IN_W-1:0] vel_a_y;
  logic signed [cpct_pkg::IN_W-1:0] vel_b_x;
  logic signed [cpct_pkg::IN_W-1:0] vel_b_y;

  modport source (output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
                  vel_a_x, vel_a_y, vel_b_x, vel_b_y, input ready);
  modport sink   (input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
                  vel_a_x, vel_a_y, vel_b_x, vel_b_y, output ready);
endinterface

>>> rtl/cpct_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpct_out_if
// Output channel: hit flag and contact time per item.
// ----------------------------------------------------------------------------
interface cpct_out_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic signed [cpct_pkg::TIME_W-1:0] contact_time;

  modport source (output valid, hit, contact_time, input ready);
  modport sink   (input valid, hit, contact_time, output ready);
endinterface

>>> rtl/circle_pair_collision_time.sv
`timescale 1ns / 1ps
// Stages from input to output:
//   5 front stages, 34 square-root cells, 1 numerator stage, 35 + FRAC_BITS
//   division cells, 1 output register.
// Throughput: one item per cycle; each stage moves on when the next has room.
// Reset: all stage valid bits clear, contact_distance_sq returns to 671089.
// ----------------------------------------------------------------------------
// circle_pair_collision_time
// Earliest contact time of two moving circles, as a chain of root and
// division cells behind a multiply front end.
// ----------------------------------------------------------------------------
`include "circle_pair_collision_time_macros.svh"

module circle_pair_collision_time #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpct_pkg::CFG_W-1:0]      cfg_wdata_i,
  cpct_in_if.sink                         in_i,
  cpct_out_if.source                      out_o
);

  localparam int unsigned QW       = cpct_pkg::MAG_W + FRAC_BITS;
  localparam int unsigned SQ_BASE  = 5;
  localparam int unsigned NUM_ST   = SQ_BASE + cpct_pkg::SQ_N;
  localparam int unsigned DIV_BASE = NUM_ST + 1;
  localparam int unsigned OUT_ST   = DIV_BASE + QW;
  localparam int unsigned NST      = OUT_ST + 1;
  localparam int unsigned QCW      = QW + 1;
  localparam int unsigned TW       = cpct_pkg::TIME_W;

  logic [cpct_pkg::CFG_W-1:0] cds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cds_q <= cpct_pkg::CDS_RESET;
    end else if (cfg_we_i) begin
      cds_q <= cfg_wdata_i;
    end
  end

  // stage valids and the ready chain (a stage loads when it is empty or drains)
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_o.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_i.ready = rdy[0];

  // ---------------- front end ----------------
  logic [SQ_BASE-1:0] fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      if (rdy[0]) fv_q[0] <= in_i.valid;
      for (int k = 1; k < SQ_BASE; k++) begin
        if (rdy[k]) fv_q[k] <= fv_q[k-1];
      end
    end
  end

  assign v[SQ_BASE-1:0] = fv_q;

  // stage 0: relative position and velocity
  logic signed [cpct_pkg::DIF_W-1:0] px_q, py_q, vx_q, vy_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      px_q <= {in_i.pos_a_x[15], in_i.pos_a_x} - {in_i.pos_b_x[15], in_i.pos_b_x};
      py_q <= {in_i.pos_a_y[15], in_i.pos_a_y} - {in_i.pos_b_y[15], in_i.pos_b_y};
      vx_q <= {in_i.vel_a_x[15], in_i.vel_a_x} - {in_i.vel_b_x[15], in_i.vel_b_x};
      vy_q <= {in_i.vel_a_y[15], in_i.vel_a_y} - {in_i.vel_b_y[15], in_i.vel_b_y};
    end
  end

  // stage 1: products
  logic signed [cpct_pkg::PRD_W-1:0] pxx_q, pyy_q, vxx_q, vyy_q, pxv_q, pyv_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      pxx_q <= cpct_pkg::PRD_W'(px_q) * cpct_pkg::PRD_W'(px_q);
      pyy_q <= cpct_pkg::PRD_W'(py_q) * cpct_pkg::PRD_W'(py_q);
      vxx_q <= cpct_pkg::PRD_W'(vx_q) * cpct_pkg::PRD_W'(vx_q);
      vyy_q <= cpct_pkg::PRD_W'(vy_q) * cpct_pkg::PRD_W'(vy_q);
      pxv_q <= cpct_pkg::PRD_W'(px_q) * cpct_pkg::PRD_W'(vx_q);
      pyv_q <= cpct_pkg::PRD_W'(py_q) * cpct_pkg::PRD_W'(vy_q);
    end
  end

  // stage 2: a, h, c
  logic [cpct_pkg::A_W-1:0]        a2_q;
  logic signed [cpct_pkg::H_W-1:0] h2_q;
  logic signed [cpct_pkg::C_W-1:0] c2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      a2_q <= cpct_pkg::A_W'(vxx_q + vyy_q);
      h2_q <= cpct_pkg::H_W'(pxv_q) + cpct_pkg::H_W'(pyv_q);
      c2_q <= cpct_pkg::C_W'(pxx_q) + cpct_pkg::C_W'(pyy_q)
              - $signed({3'b000, cds_q});
    end
  end

  // stage 3: h^2 and a*|c|
  logic [cpct_pkg::M_W-1:0]        hm, cm;
  logic                            cneg3_q;
  logic [cpct_pkg::A_W-1:0]        a3_q;
  logic signed [cpct_pkg::H_W-1:0] h3_q;
  logic [cpct_pkg::D_W-1:0]        hh3_q, ac3_q;

  always_comb begin
    hm = h2_q[cpct_pkg::H_W-1] ? cpct_pkg::M_W'(-h2_q) : cpct_pkg::M_W'(h2_q);
    cm = c2_q[cpct_pkg::C_W-1] ? cpct_pkg::M_W'(-c2_q) : cpct_pkg::M_W'(c2_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      cneg3_q <= c2_q[cpct_pkg::C_W-1];
      a3_q    <= a2_q;
      h3_q    <= h2_q;
      hh3_q   <= cpct_pkg::D_W'(hm) * cpct_pkg::D_W'(hm);
      ac3_q   <= cpct_pkg::D_W'(a2_q) * cpct_pkg::D_W'(cm);
    end
  end

  // stage 4: discriminant / 4 and hit decision
  cpct_pkg::sq_t sq4_d, sq4_q;

  always_comb begin
    sq4_d      = '0;
    sq4_d.h    = h3_q;
    sq4_d.a    = a3_q;
    if (!cneg3_q) begin
      sq4_d.hit = (ac3_q < hh3_q);
      sq4_d.d   = sq4_d.hit ? (hh3_q - ac3_q) : hh3_q;
    end else begin
      sq4_d.d   = hh3_q + ac3_q;
      sq4_d.hit = (sq4_d.d != '0);
    end
    // no relative motion is always a miss
    if (a3_q == '0) sq4_d.hit = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      sq4_q <= sq4_d;
    end
  end

  // ---------------- square-root chain ----------------
  logic          sqv [0:cpct_pkg::SQ_N];
  cpct_pkg::sq_t sqd [0:cpct_pkg::SQ_N];

  assign sqv[0] = fv_q[SQ_BASE-1];
  assign sqd[0] = sq4_q;

  for (genvar g = 0; g < cpct_pkg::SQ_N; g++) begin : g_sqrt
    cpct_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (rdy[SQ_BASE+g]),
      .vld_i  (sqv[g]),
      .dat_i  (sqd[g]),
      .vld_o  (sqv[g+1]),
      .dat_o  (sqd[g+1])
    );
    assign v[SQ_BASE+g] = sqv[g+1];
  end

  // ---------------- numerator -h - s ----------------
  logic signed [cpct_pkg::NUM_W-1:0] num;
  logic                              numv_q, nhit_q, nneg_q;
  logic [cpct_pkg::A_W-1:0]          na_q;
  logic [cpct_pkg::MAG_W-1:0]        nmag_q;

  assign num = -cpct_pkg::NUM_W'(sqd[cpct_pkg::SQ_N].h)
               - $signed({2'b00, sqd[cpct_pkg::SQ_N].root});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numv_q <= 1'b0;
    end else if (rdy[NUM_ST]) begin
      numv_q <= sqv[cpct_pkg::SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NUM_ST]) begin
      nhit_q <= sqd[cpct_pkg::SQ_N].hit;
      na_q   <= sqd[cpct_pkg::SQ_N].a;
      nneg_q <= num[cpct_pkg::NUM_W-1];
      nmag_q <= num[cpct_pkg::NUM_W-1] ? cpct_pkg::MAG_W'(-num) : cpct_pkg::MAG_W'(num);
    end
  end

  assign v[NUM_ST] = numv_q;

  // ---------------- division chain ----------------
  logic                     dv   [0:QW];
  logic                     dhit [0:QW];
  logic                     dneg [0:QW];
  logic [cpct_pkg::A_W-1:0] da   [0:QW];
  logic [cpct_pkg::A_W-1:0] drem [0:QW];
  logic [QW-1:0]            ddvd [0:QW];
  logic [QW-1:0]            dquo [0:QW];

  assign dv[0]   = numv_q;
  assign dhit[0] = nhit_q;
  assign dneg[0] = nneg_q;
  assign da[0]   = na_q;
  assign drem[0] = '0;
  assign ddvd[0] = {nmag_q, {FRAC_BITS{1'b0}}};
  assign dquo[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    cpct_div_cell #(.QW(QW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (rdy[DIV_BASE+g]),
      .vld_i  (dv[g]),
      .hit_i  (dhit[g]),
      .neg_i  (dneg[g]),
      .a_i    (da[g]),
      .rem_i  (drem[g]),
      .dvd_i  (ddvd[g]),
      .quo_i  (dquo[g]),
      .vld_o  (dv[g+1]),
      .hit_o  (dhit[g+1]),
      .neg_o  (dneg[g+1]),
      .a_o    (da[g+1]),
      .rem_o  (drem[g+1]),
      .dvd_o  (ddvd[g+1]),
      .quo_o  (dquo[g+1])
    );
    assign v[DIV_BASE+g] = dv[g+1];
  end

  // ---------------- rounding, saturation, output register ----------------
  logic [QCW-1:0] qc;
  logic [TW-1:0]  t_d;
  logic           ov_q, ohit_q;
  logic [TW-1:0]  ot_q;

  always_comb begin
    // negative quotients round toward minus infinity: ceil of magnitude
    qc = {1'b0, dquo[QW]} + QCW'(dneg[QW] && (drem[QW] != '0));
    if (!dhit[QW]) begin
      t_d = TW'(0) - (TW'(1) << FRAC_BITS);
    end else if (!dneg[QW]) begin
      t_d = (qc > QCW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qc[TW-1:0];
    end else begin
      t_d = (qc > QCW'(33'h0_8000_0000)) ? 32'h8000_0000 : (TW'(0) - qc[TW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rdy[OUT_ST]) begin
      ov_q <= dv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[OUT_ST]) begin
      ohit_q <= dhit[QW];
      ot_q   <= t_d;
    end
  end

  assign v[OUT_ST]          = ov_q;
  assign out_o.valid        = ov_q;
  assign out_o.hit          = ohit_q;
  assign out_o.contact_time = ot_q;

  // ---------------- assertions ----------------
  `CPCT_ASSERT_IMPL(a_miss_time, clk_i, rst_ni, out_o.valid && !out_o.hit,
                    out_o.contact_time == (TW'(0) - (TW'(1) << FRAC_BITS)))
  `CPCT_ASSERT_IMPL(a_ready_when_out_empty, clk_i, rst_ni, !ov_q, in_i.ready)
  `CPCT_ASSERT_NEXT(a_accept_fills_stage0, clk_i, rst_ni,
                    in_i.valid && in_i.ready, fv_q[0])
  `CPCT_ASSERT_IMPL(a_no_hit_without_motion, clk_i, rst_ni,
                    fv_q[SQ_BASE-1] && (sq4_q.a == '0), !sq4_q.hit)

endmodule

>>> rtl/cpct_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpct_sqrt_cell
// One digit of a restoring integer square root; produces one root bit.
// ----------------------------------------------------------------------------
module cpct_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  cpct_pkg::sq_t dat_i,
  output logic          vld_o,
  output cpct_pkg::sq_t dat_o
);

  localparam int unsigned T_W = cpct_pkg::REM_W + 2;

  logic          vld_q;
  cpct_pkg::sq_t dat_q, dat_d;
  logic [T_W-1:0] trial, test;
  logic           ge;

  always_comb begin
    trial = {dat_i.rem, dat_i.d[cpct_pkg::D_W-1 -: 2]};
    test  = {2'b00, dat_i.root, 2'b01};
    ge    = (trial >= test);
    dat_d      = dat_i;
    dat_d.d    = dat_i.d << 2;
    dat_d.root = {dat_i.root[cpct_pkg::R_W-2:0], ge};
    dat_d.rem  = ge ? cpct_pkg::REM_W'(trial - test) : cpct_pkg::REM_W'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

>>> rtl/cpct_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpct_div_cell
// One step of restoring long division by a; produces one quotient bit.
// ----------------------------------------------------------------------------
module cpct_div_cell #(
  parameter int unsigned QW = 47
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic                       hit_i,
  input  logic                       neg_i,
  input  logic [cpct_pkg::A_W-1:0]   a_i,
  input  logic [cpct_pkg::A_W-1:0]   rem_i,
  input  logic [QW-1:0]              dvd_i,
  input  logic [QW-1:0]              quo_i,
  output logic                       vld_o,
  output logic                       hit_o,
  output logic                       neg_o,
  output logic [cpct_pkg::A_W-1:0]   a_o,
  output logic [cpct_pkg::A_W-1:0]   rem_o,
  output logic [QW-1:0]              dvd_o,
  output logic [QW-1:0]              quo_o
);

  localparam int unsigned T_W = cpct_pkg::A_W + 1;

  logic                     vld_q, hit_q, neg_q;
  logic [cpct_pkg::A_W-1:0] a_q, rem_q, rem_d;
  logic [QW-1:0]            dvd_q, quo_q;
  logic [T_W-1:0]           r2;
  logic                     ge;

  always_comb begin
    r2    = {rem_i, dvd_i[QW-1]};
    ge    = (r2 >= {1'b0, a_i});
    rem_d = ge ? cpct_pkg::A_W'(r2 - {1'b0, a_i}) : r2[cpct_pkg::A_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_i;
      neg_q <= neg_i;
      a_q   <= a_i;
      rem_q <= rem_d;
      dvd_q <= dvd_i << 1;
      quo_q <= {quo_i[QW-2:0], ge};
    end
  end

  assign vld_o = vld_q;
  assign hit_o = hit_q;
  assign neg_o = neg_q;
  assign a_o   = a_q;
  assign rem_o = rem_q;
  assign dvd_o = dvd_q;
  assign quo_o = quo_q;

endmodule
